FILE: hdl/sdt_pkg.sv
// Shared types, constants and helpers of the style tuple dedup table.
`default_nettype none

package sdt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ENTRY_W     = 8;
	localparam int LM_W        = 11;
	localparam int STYLE_W     = 8;
	localparam int SLOTS       = 4;
	localparam int MASK_W      = SLOTS - 1;
	localparam int KEY_W       = SLOTS * (LM_W + 2 * STYLE_W);
	localparam int IN_DATA_W   = ((KEY_W + 7) / 8) * 8;

	localparam logic [STYLE_W-1:0] STYLE_UNUSED = '1;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Slot 0 lightmap sits in the low bits, vertex styles in the high bits.
	typedef struct packed {
		logic [SLOTS-1:0][STYLE_W-1:0] vs;
		logic [SLOTS-1:0][STYLE_W-1:0] ms;
		logic [SLOTS-1:0][LM_W-1:0]    lm;
	} key_t;

	typedef struct packed {
		logic [MASK_W-1:0]  vertex_color_mask;
		logic [MASK_W-1:0]  map_coord_mask;
		status_t            status;
		logic [ENTRY_W-1:0] entry_index;
	} res_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		key_t             wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	function automatic logic [MASK_W-1:0] style_mask(input logic [SLOTS-1:0][STYLE_W-1:0] s);
		logic [MASK_W-1:0] m;
		m[0] = (s[1] != STYLE_UNUSED);
		m[1] = (s[2] != STYLE_UNUSED);
		m[2] = (s[3] != STYLE_UNUSED);
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/style_tuple_dedup_table.sv
// Top level of the style tuple dedup table: stream ports, key storage and scan sequencer.
//
//   Channel  Dir  Handshake         Payload
//   s_*      in   s_tvalid/s_tready s_tdata: lightmap key, map styles, vertex styles
//   m_*      out  m_tvalid/m_tready m_tdata: entry index, status, feature masks
//
// An item is compared against the stored entries one per cycle through a single read
// port, up to all 256 entries of a full table, and the scan ends early when an entry
// matches; the next item is accepted only after the previous item's scan has ended.
// Reset clears the entry count and control state; stored keys are not cleared.
// A result waits in the output register while the next item is accepted and scanned;
// a later result, and with it the next item, is held while that register is occupied.
`default_nettype none

module style_tuple_dedup_table
	import sdt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// lightmap_slot0..3 (11 bits each), map_style_slot0..3, vertex_style_slot0..3, zero fill
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// entry_index (8), status (2), map_coord_mask (3), vertex_color_mask (3)
	output logic [$bits(res_t)-1:0]   m_tdata
);

	key_t     in_key;
	res_t     out_res;
	mem_req_t mem_req;
	key_t     mem_rdata;

	assign in_key  = key_t'(s_tdata[KEY_W-1:0]);
	assign m_tdata = out_res;

	sdt_key_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rdata)
	);

	sdt_scan_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_key    (in_key),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule

`default_nettype wire

FILE: hdl/sdt_key_mem.sv
// Key storage of the dedup table: one write port and one registered read port.
`default_nettype none

module sdt_key_mem
	import sdt_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output key_t          rd_data
);

	key_t mem_q [TABLE_DEPTH];
	key_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: hdl/sdt_scan_ctrl.sv
// Scan sequencer with the shared key comparator, entry counter and result register.
`default_nettype none

module sdt_scan_ctrl
	import sdt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire key_t     in_key,
	output logic          out_valid,
	input  wire logic     out_ready,
	output res_t          out_res,
	output mem_req_t      mem_req,
	input  wire key_t     mem_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	key_t             key_q;
	res_t             res_q;
	res_t             out_q;
	logic             out_v_q;

	logic issue;
	logic hit;
	logic miss;
	logic full;
	logic out_free;
	logic out_load;

	assign issue    = (state_q == S_SCAN) && (ptr_q < count_q);
	assign hit      = (state_q == S_SCAN) && rd_v_s1 && (mem_rdata == key_q);
	assign miss     = (state_q == S_SCAN) && !rd_v_s1 && !issue;
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign out_free = !out_v_q || out_ready;
	assign out_load = (state_q == S_DONE) && out_free;

	always_comb begin
		mem_req.rd_en   = issue && !hit;
		mem_req.rd_addr = ptr_q[IDX_W-1:0];
		mem_req.wr_en   = miss && !full;
		mem_req.wr_addr = count_q[IDX_W-1:0];
		mem_req.wr_data = key_q;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_q   <= res_q;
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q   <= in_key;
						ptr_q   <= '0;
						rd_v_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_v_s1   <= mem_req.rd_en;
					rd_idx_s1 <= ptr_q[IDX_W-1:0];
					if (mem_req.rd_en) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					res_q.map_coord_mask    <= style_mask(key_q.ms);
					res_q.vertex_color_mask <= style_mask(key_q.vs);
					if (hit) begin
						res_q.status      <= ST_FOUND;
						res_q.entry_index <= ENTRY_W'(rd_idx_s1);
						state_q           <= S_DONE;
					end else if (miss) begin
						if (full) begin
							res_q.status      <= ST_FULL;
							res_q.entry_index <= '0;
						end else begin
							res_q.status      <= ST_ADDED;
							res_q.entry_index <= ENTRY_W'(count_q);
							count_q           <= count_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> (CNT_W'(mem_req.rd_addr) < count_q))
		else $error("read of an entry that was never written");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not advance the entry count");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> !full)
		else $error("append into a full table");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new item taken while a scan is running");

endmodule

`default_nettype wire
